FILE: rtl/core/xyc_pkg.sv
package xyc_pkg;

    // Conversion direction carried in tuser
    typedef enum logic {
        KIND_XYZ_TO_YXY = 1'b0,
        KIND_YXY_TO_XYZ = 1'b1
    } kind_t;

endpackage

FILE: rtl/core/xyz_yxy_converter.sv
// XYZ <-> Yxy converter. One pixel per clock sustained while the output
// is taken. A setup stage and a registered multiply come first, then the
// pipelined restoring divider: the two quotients run through one register
// stage per quotient bit (PROD_W = 2*CHANNEL_BITS + 2 stages) before the
// output register.
// Saturation is combinational in front of the output register. tuser bit 0
// selects the direction (0: XYZ to Yxy, 1: Yxy to XYZ), and the output tuser
// carries the saturation flag. Results leave in input order. s_tready drops
// only when the output register holds a result that is not taken, and the
// whole pipe then holds.
module xyz_yxy_converter #(
    parameter int CHANNEL_BITS = 32,
    parameter int FRAC_BITS    = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata: in_ch0, in_ch1, in_ch2 from the lowest bit up
    input  logic [3*CHANNEL_BITS-1:0] s_tdata,
    // tuser: kind
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata: out_ch0, out_ch1, out_ch2 from the lowest bit up
    output logic [3*CHANNEL_BITS-1:0] m_tdata,
    // tuser: overflow
    output logic                      m_tuser
);

    localparam int CW     = CHANNEL_BITS;
    localparam int DEN_W  = CW + 2;           // w = sum of three channels
    localparam int MAG_W  = CW + 2;           // |num| incl. ONE-x-y
    localparam int PROD_W = 2 * CW + 2;       // magnitude product width
    localparam int NST    = PROD_W;           // divider steps

    // Stall: whole pipe advances together
    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 1: decode, operand setup ----------------
    logic                    v1_reg;
    logic signed [MAG_W-1:0] na1_reg, nb1_reg;      // signed numerators
    logic [MAG_W-1:0]        mul1_reg;              // multiplier
    logic [DEN_W-1:0]        den1_reg;
    logic                    go1_reg;
    logic signed [CW-1:0]    pass1_reg;
    logic                    kind1_reg;

    logic signed [CW-1:0] c0, c1, c2;
    logic signed [DEN_W-1:0] w_sum;
    assign c0 = s_tdata[CW-1:0];
    assign c1 = s_tdata[2*CW-1:CW];
    assign c2 = s_tdata[3*CW-1:2*CW];
    assign w_sum = DEN_W'(c0) + DEN_W'(c1) + DEN_W'(c2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg <= s_tuser;
            if (xyc_pkg::kind_t'(s_tuser) == xyc_pkg::KIND_XYZ_TO_YXY)
            begin
                na1_reg   <= MAG_W'(c0);
                nb1_reg   <= MAG_W'(c1);
                mul1_reg  <= MAG_W'(1) << FRAC_BITS;
                den1_reg  <= w_sum;
                go1_reg   <= (w_sum > 0);
                pass1_reg <= c1;
            end
            else
            begin
                na1_reg   <= MAG_W'(c1);
                nb1_reg   <= (MAG_W'(1) << FRAC_BITS) - MAG_W'(c1) - MAG_W'(c2);
                mul1_reg  <= MAG_W'(c0);
                den1_reg  <= DEN_W'(c2);
                go1_reg   <= (c0 > 0) && (c1 > 0) && (c2 > 0);
                pass1_reg <= c0;
            end
        end
    end

    // Divider pipeline registers; slot 0 is loaded by the multiply stage
    logic [NST:0]             dv_reg;
    logic [PROD_W-1:0]        qa_reg [NST+1];
    logic [PROD_W-1:0]        qb_reg [NST+1];
    logic [DEN_W:0]           ra_reg [NST+1];
    logic [DEN_W:0]           rb_reg [NST+1];
    logic [DEN_W-1:0]         dd_reg [NST+1];
    logic [NST:0]             dsa_reg, dsb_reg, dgo_reg, dkind_reg;
    logic signed [CW-1:0]     dpass_reg [NST+1];

    // ---------------- stage 2: magnitude products ----------------
    logic [MAG_W-1:0]     ma1, mb1;
    assign ma1 = na1_reg[MAG_W-1] ? MAG_W'(-na1_reg) : MAG_W'(na1_reg);
    assign mb1 = nb1_reg[MAG_W-1] ? MAG_W'(-nb1_reg) : MAG_W'(nb1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (adv)
            dv_reg[0] <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qa_reg[0]    <= PROD_W'(ma1) * PROD_W'(mul1_reg);
            qb_reg[0]    <= PROD_W'(mb1) * PROD_W'(mul1_reg);
            ra_reg[0]    <= '0;
            rb_reg[0]    <= '0;
            dd_reg[0]    <= go1_reg ? den1_reg : DEN_W'(1);
            dsa_reg[0]   <= na1_reg[MAG_W-1];
            dsb_reg[0]   <= nb1_reg[MAG_W-1];
            dgo_reg[0]   <= go1_reg;
            dkind_reg[0] <= kind1_reg;
            dpass_reg[0] <= pass1_reg;
        end
    end

    // ---------------- divider pipeline: one quotient bit per stage --------
    for (genvar g = 0; g < NST; g++)
    begin : g_div
        logic [PROD_W-1:0] qa_n, qb_n;
        logic [DEN_W:0]    ra_n, rb_n;

        xyc_divstage #(.NUM_W(PROD_W), .DEN_W(DEN_W)) u_da (
            .num_in(qa_reg[g]), .rem_in(ra_reg[g]), .den(dd_reg[g]),
            .num_out(qa_n), .rem_out(ra_n)
        );
        xyc_divstage #(.NUM_W(PROD_W), .DEN_W(DEN_W)) u_db (
            .num_in(qb_reg[g]), .rem_in(rb_reg[g]), .den(dd_reg[g]),
            .num_out(qb_n), .rem_out(rb_n)
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[g+1] <= 1'b0;
            else if (adv)
                dv_reg[g+1] <= dv_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                qa_reg[g+1]    <= qa_n;
                qb_reg[g+1]    <= qb_n;
                ra_reg[g+1]    <= ra_n;
                rb_reg[g+1]    <= rb_n;
                dd_reg[g+1]    <= dd_reg[g];
                dsa_reg[g+1]   <= dsa_reg[g];
                dsb_reg[g+1]   <= dsb_reg[g];
                dgo_reg[g+1]   <= dgo_reg[g];
                dkind_reg[g+1] <= dkind_reg[g];
                dpass_reg[g+1] <= dpass_reg[g];
            end
        end
    end

    // ---------------- saturate and output register ----------------
    localparam logic [PROD_W-1:0] POS_LIM = PROD_W'((65'(1) << (CW - 1)) - 1);
    localparam logic [PROD_W-1:0] NEG_LIM = PROD_W'(65'(1) << (CW - 1));

    logic [CW-1:0] res_a, res_b;
    logic          sat_a, sat_b;

    always_comb
    begin
        logic [PROD_W-1:0] qa, qb, la, lb;
        qa = qa_reg[NST];
        qb = qb_reg[NST];
        la = dsa_reg[NST] ? NEG_LIM : POS_LIM;
        lb = dsb_reg[NST] ? NEG_LIM : POS_LIM;
        sat_a = dgo_reg[NST] && (qa > la);
        sat_b = dgo_reg[NST] && (qb > lb);
        if (sat_a) qa = la;
        if (sat_b) qb = lb;
        res_a = dsa_reg[NST] ? CW'(-qa) : CW'(qa);
        res_b = dsb_reg[NST] ? CW'(-qb) : CW'(qb);
        if (!dgo_reg[NST])
        begin
            res_a = '0;
            res_b = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (adv)
            m_tvalid <= dv_reg[NST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tuser <= sat_a || sat_b;
            if (xyc_pkg::kind_t'(dkind_reg[NST]) == xyc_pkg::KIND_XYZ_TO_YXY)
                m_tdata <= {res_b, res_a, dpass_reg[NST]};
            else
                m_tdata <= {res_b, dpass_reg[NST], res_a};
        end
    end

`ifndef SYNTHESIS
    // Output held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    // Ready only follows output side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("ready mismatch");
    // No overflow on non-computed pixels
    a_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        !dgo_reg[NST] |-> !(sat_a || sat_b))
        else $error("overflow without computation");
`endif

endmodule

FILE: rtl/core/xyc_divstage.sv
// One restoring-division step on a magnitude pair: shifts one numerator bit
// into the partial remainder and sets one quotient bit.
module xyc_divstage #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 40
) (
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W:0]   rem_in,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] num_out,
    output logic [DEN_W:0]   rem_out
);

    logic [DEN_W+1:0] shifted;
    logic [DEN_W+1:0] diff;

    always_comb
    begin
        shifted = {rem_in, num_in[NUM_W-1]};
        diff    = shifted - {1'b0, 1'b0, den};
        if (!diff[DEN_W+1])
        begin
            rem_out = diff[DEN_W:0];
            num_out = {num_in[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_out = shifted[DEN_W:0];
            num_out = {num_in[NUM_W-2:0], 1'b0};
        end
    end

endmodule
